[src/complex_arithmetic_unit_assert.svh]
// Assertion macros for the complex arithmetic unit checker.
// Used by cau_checker; depends on nothing else.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define CAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while in reset.
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/cau_pkg.sv]
// Shared constants, types and helpers of the complex arithmetic unit.
// No dependencies; used by every module of the block.
package cau_pkg;

  localparam int CAU_FRAC_BITS = 16;
  // Division/root chain: one quotient bit per cell, top bit flags overflow.
  localparam int CAU_STEPS = 34;
  localparam int CAU_QW    = CAU_STEPS;
  // Remainder must hold divisor << (CAU_STEPS-1) and magnitude << FRAC_BITS.
  localparam int CAU_RW    = 97;
  // Root register holds the first trial bit 2^(2*(CAU_STEPS-1)).
  localparam int CAU_SW    = 2 * (CAU_STEPS - 1) + 2;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_SCALE = 3'd3,
    CMD_DIV   = 3'd4,
    CMD_MOD   = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [31:0]       q_re;
    logic [31:0]       q_im;
    logic              q_sat;
    logic              dz;
    logic              neg_re;
    logic              neg_im;
    logic [63:0]       dvs;
    logic [CAU_RW-1:0] rem_re;
    logic [CAU_RW-1:0] rem_im;
    logic [CAU_QW-1:0] quo_re;
    logic [CAU_QW-1:0] quo_im;
    logic [63:0]       sq_rem;
    logic [CAU_SW-1:0] sq_root;
  } cau_lane_t;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        sat;
    logic        dz;
  } cau_res_t;

  // Clamp to signed 32 bits; returns {clamped, value}.
  function automatic logic [32:0] cau_clamp(input logic signed [65:0] v);
    logic [32:0] r;
    r = {1'b0, v[31:0]};
    if (v > 66'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -66'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end
    return r;
  endfunction

endpackage

[src/cau_cell.sv]
// One cell of the divide/root chain: one quotient bit of each divide part
// and one root bit of the modulus. Depends on cau_pkg.
module cau_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_in,
  input  cau_pkg::cau_lane_t lane_in,
  output logic              valid_r,
  output cau_pkg::cau_lane_t lane_r
);

  localparam int SH = cau_pkg::CAU_STEPS - 1 - IDX;
  localparam int BP = 2 * SH;
  localparam int RW = cau_pkg::CAU_RW;
  localparam int SW = cau_pkg::CAU_SW;

  cau_pkg::cau_lane_t lane_nxt;

  always_comb begin
    logic [RW-1:0] dsh;
    logic [SW-1:0] bitv;
    logic [SW-1:0] trial;
    lane_nxt = lane_in;
    dsh   = {{(RW-64){1'b0}}, lane_in.dvs} << SH;
    bitv  = {{(SW-1){1'b0}}, 1'b1} << BP;
    trial = lane_in.sq_root + bitv;
    if (lane_in.rem_re >= dsh) begin
      lane_nxt.rem_re     = lane_in.rem_re - dsh;
      lane_nxt.quo_re[SH] = 1'b1;
    end
    if (lane_in.rem_im >= dsh) begin
      lane_nxt.rem_im     = lane_in.rem_im - dsh;
      lane_nxt.quo_im[SH] = 1'b1;
    end
    if ({{(SW-64){1'b0}}, lane_in.sq_rem} >= trial) begin
      lane_nxt.sq_rem  = lane_in.sq_rem - trial[63:0];
      lane_nxt.sq_root = (lane_in.sq_root >> 1) + bitv;
    end else begin
      lane_nxt.sq_root = lane_in.sq_root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

[src/cau_front.sv]
// Front end: product stage, then sums, rounding and chain setup.
// Depends on cau_pkg.
module cau_front #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_in,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               valid_r,
  output cau_pkg::cau_lane_t lane_r
);

  localparam int RW = cau_pkg::CAU_RW;
  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

  logic               v1_r;
  logic [2:0]         cmd1_r;
  logic signed [31:0] ar1_r, ai1_r, br1_r, bi1_r;
  logic signed [63:0] arbr_r, aibi_r, arbi_r, aibr_r;
  logic signed [63:0] arar_r, aiai_r, brbr_r, bibi_r;
  cau_pkg::cau_lane_t lane_nxt;

  function automatic logic signed [65:0] sx66(input logic signed [63:0] x);
    return {{2{x[63]}}, x};
  endfunction

  function automatic logic [32:0] rnd(input logic signed [65:0] s);
    logic signed [65:0] t;
    t = (s + HALF) >>> FRAC_BITS;
    return cau_pkg::cau_clamp(t);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      valid_r <= 1'b0;
    end else if (en) begin
      v1_r    <= valid_in;
      valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= cmd;
      ar1_r  <= a_re;
      ai1_r  <= a_im;
      br1_r  <= b_re;
      bi1_r  <= b_im;
      arbr_r <= a_re * b_re;
      aibi_r <= a_im * b_im;
      arbi_r <= a_re * b_im;
      aibr_r <= a_im * b_re;
      arar_r <= a_re * a_re;
      aiai_r <= a_im * a_im;
      brbr_r <= b_re * b_re;
      bibi_r <= b_im * b_im;
      lane_r <= lane_nxt;
    end
  end

  always_comb begin
    logic [32:0]        c_re, c_im;
    logic signed [65:0] n_re, n_im;
    logic [63:0]        m_re, m_im;
    lane_nxt = '0;
    c_re = '0;
    c_im = '0;
    lane_nxt.cmd = cmd1_r;
    unique case (cmd1_r)
      cau_pkg::CMD_ADD: begin
        c_re = cau_pkg::cau_clamp(66'(ar1_r) + 66'(br1_r));
        c_im = cau_pkg::cau_clamp(66'(ai1_r) + 66'(bi1_r));
      end
      cau_pkg::CMD_SUB: begin
        c_re = cau_pkg::cau_clamp(66'(ar1_r) - 66'(br1_r));
        c_im = cau_pkg::cau_clamp(66'(ai1_r) - 66'(bi1_r));
      end
      cau_pkg::CMD_MUL: begin
        c_re = rnd(sx66(arbr_r) - sx66(aibi_r));
        c_im = rnd(sx66(arbi_r) + sx66(aibr_r));
      end
      cau_pkg::CMD_SCALE: begin
        c_re = rnd(sx66(arbr_r));
        c_im = rnd(sx66(aibr_r));
      end
      default: begin
        c_re = '0;
        c_im = '0;
      end
    endcase
    lane_nxt.q_re  = c_re[31:0];
    lane_nxt.q_im  = c_im[31:0];
    lane_nxt.q_sat = c_re[32] | c_im[32];
    // Divide: numerators of a * conj(b), split into sign and magnitude.
    n_re = sx66(arbr_r) + sx66(aibi_r);
    n_im = sx66(aibr_r) - sx66(arbi_r);
    m_re = n_re[65] ? 64'(-n_re) : n_re[63:0];
    m_im = n_im[65] ? 64'(-n_im) : n_im[63:0];
    lane_nxt.neg_re = n_re[65];
    lane_nxt.neg_im = n_im[65];
    lane_nxt.dvs    = brbr_r + bibi_r;
    lane_nxt.dz     = (brbr_r == 64'sd0) && (bibi_r == 64'sd0);
    lane_nxt.rem_re = {{(RW-64){1'b0}}, m_re} << FRAC_BITS;
    lane_nxt.rem_im = {{(RW-64){1'b0}}, m_im} << FRAC_BITS;
    lane_nxt.sq_rem = arar_r + aiai_r;
  end

endmodule

[src/cau_back.sv]
// Result select: picks the chain outputs or the early result, clamps them.
// Depends on cau_pkg.
module cau_back (
  input  cau_pkg::cau_lane_t lane,
  output cau_pkg::cau_res_t  res
);

  localparam int QW = cau_pkg::CAU_QW;
  localparam int SW = cau_pkg::CAU_SW;

  function automatic logic [32:0] fin(input logic [QW-1:0] q, input logic neg);
    logic [32:0] r;
    if (neg) begin
      if (q > QW'(34'h0_8000_0000)) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'(-q[31:0])};
    end else begin
      if (q > QW'(34'h0_7fff_ffff)) r = {1'b1, 32'h7fff_ffff};
      else r = {1'b0, q[31:0]};
    end
    return r;
  endfunction

  always_comb begin
    logic [32:0] d_re, d_im;
    d_re = fin(lane.quo_re, lane.neg_re);
    d_im = fin(lane.quo_im, lane.neg_im);
    res  = '0;
    unique case (lane.cmd)
      cau_pkg::CMD_DIV: begin
        if (lane.dz) begin
          res.dz = 1'b1;
        end else begin
          res.re  = d_re[31:0];
          res.im  = d_im[31:0];
          res.sat = d_re[32] | d_im[32];
        end
      end
      cau_pkg::CMD_MOD: begin
        if (lane.sq_root > SW'(32'h7fff_ffff)) begin
          res.re  = 32'h7fff_ffff;
          res.sat = 1'b1;
        end else begin
          res.re = lane.sq_root[31:0];
        end
      end
      default: begin
        res.re  = lane.q_re;
        res.im  = lane.q_im;
        res.sat = lane.q_sat;
      end
    endcase
  end

endmodule

[src/complex_arithmetic_unit.sv]
// Complex arithmetic unit: add, subtract, multiply, scale, divide and modulus
// on signed fixed-point operands. One beat is taken per cycle while the skid
// register is empty; each result passes two front stages, 34 chain cells and
// one output register, and the chain of cells gives one quotient and one root
// bit per cell. An output skid register catches one more result while a
// result is held back; the input stalls only while that register is full.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // a_re, a_im, b_re, b_im
  input  logic [2:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // res_re, res_im
  output logic [1:0]   out_tuser   // saturated, divide_by_zero
);

  localparam int STEPS = cau_pkg::CAU_STEPS;

  logic               en;
  logic               skid_full_r;
  cau_pkg::cau_res_t  skid_r;
  cau_pkg::cau_res_t  out_r;
  logic               out_valid_r;
  cau_pkg::cau_res_t  tail_res;

  logic               v_r [STEPS+1];
  cau_pkg::cau_lane_t l_r [STEPS+1];

  assign en        = !skid_full_r;
  assign in_tready = en;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (in_tvalid),
    .cmd      (in_tuser),
    .a_re     (in_tdata[31:0]),
    .a_im     (in_tdata[63:32]),
    .b_re     (in_tdata[95:64]),
    .b_im     (in_tdata[127:96]),
    .valid_r  (v_r[0]),
    .lane_r   (l_r[0])
  );

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    cau_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (v_r[k]),
      .lane_in  (l_r[k]),
      .valid_r  (v_r[k+1]),
      .lane_r   (l_r[k+1])
    );
  end

  cau_back u_back (
    .lane (l_r[STEPS]),
    .res  (tail_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_full_r) begin
        out_valid_r <= 1'b1;
        skid_full_r <= 1'b0;
      end else begin
        out_valid_r <= v_r[STEPS];
      end
    end else if (v_r[STEPS] && en) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_r <= skid_full_r ? skid_r : tail_res;
    end else if (v_r[STEPS] && en) begin
      skid_r <= tail_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.im, out_r.re};
  assign out_tuser  = {out_r.dz, out_r.sat};

endmodule

[src/cau_checker.sv]
// Port-level checker for complex_arithmetic_unit, bound to the top level.
// Depends on complex_arithmetic_unit_assert.svh.
`include "complex_arithmetic_unit_assert.svh"

module cau_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic [1:0]   out_tuser
);

  `CAU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")
  `CAU_ASSERT_NOW(a_dz_zero, out_tvalid && out_tuser[1], out_tdata == 64'd0 && !out_tuser[0], "zero divisor beat not zero")
  `CAU_ASSERT_NOW(a_sat_limit, out_tvalid && out_tuser[0], out_tdata[31:0] == 32'h7fff_ffff || out_tdata[31:0] == 32'h8000_0000 || out_tdata[63:32] == 32'h7fff_ffff || out_tdata[63:32] == 32'h8000_0000, "saturated beat off the limits")
  `CAU_ASSERT_NOW(a_ready_idle, !out_tvalid, in_tready, "input stalled with empty output")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
